// ===== sv/lsi_pkg.sv =====
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants of the looped sample interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

  localparam int unsigned PosW            = 48;
  localparam int unsigned SampleW         = 16;
  localparam int unsigned CountW          = 17;
  localparam int unsigned BeginW          = 16;
  localparam int unsigned IndexW          = 16;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 17;
  localparam int unsigned DefaultDepth    = 65536;
  localparam int unsigned DefaultFracBits = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleCount = 2'd0,
    CfgLoopEnable  = 2'd1,
    CfgLoopBegin   = 2'd2,
    CfgLoopFinish  = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== sv/looped_sample_interpolator.sv =====
// Each accepted read gives a result strobe after the modulo, address, memory,
// product and output registers; writes give no result.
// Throughput: one item per cycle; the loop wrap is a restoring modulo pipeline
// with one quotient bit per stage, and the sample memory reads two entries a cycle.
// busy_o stays low, the receiver cannot stall; reset clears all valid bits and
// config registers, the sample memory is not cleared.
// ----------------------------------------------------------------------------
// looped_sample_interpolator
// Sample memory with looped, linearly interpolated playback reads.
// ----------------------------------------------------------------------------
`default_nettype none

module looped_sample_interpolator #(
  parameter int unsigned MEMORY_DEPTH  = lsi_pkg::DefaultDepth,
  parameter int unsigned FRACTION_BITS = lsi_pkg::DefaultFracBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               func_i,
  input  wire logic [lsi_pkg::IndexW-1:0]         write_index_i,
  input  wire logic signed [lsi_pkg::SampleW-1:0] write_value_i,
  input  wire logic signed [lsi_pkg::PosW-1:0]    position_i,
  output logic                                    sample_valid_o,
  output logic signed [lsi_pkg::SampleW-1:0]      sample_out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [lsi_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [lsi_pkg::CfgDataW-1:0]       cfg_data_i
);
  import lsi_pkg::*;

  localparam int unsigned IW      = PosW - FRACTION_BITS;
  localparam int unsigned FW      = FRACTION_BITS;
  localparam int unsigned AW      = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
  localparam int unsigned RW      = CountW + 1;
  localparam int unsigned LATENCY = IW + 5;

  typedef struct packed {
    logic                 rd;
    logic [IndexW-1:0]    widx;
    logic [SampleW-1:0]   wval;
    logic [FW-1:0]        frac;
    logic [IW-1:0]        ipart;
    logic [IW-1:0]        offs;
    logic                 wrap;
    logic                 pin;
  } pipe_t;

  // config registers
  logic [CountW-1:0] count_q;
  logic              loop_en_q;
  logic [BeginW-1:0] begin_q;
  logic [CountW-1:0] finish_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      loop_en_q <= 1'b0;
      begin_q   <= '0;
      finish_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSampleCount: count_q   <= cfg_data_i;
        CfgLoopEnable:  loop_en_q <= cfg_data_i[0];
        CfgLoopBegin:   begin_q   <= cfg_data_i[BeginW-1:0];
        CfgLoopFinish:  finish_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // static derived settings
  logic [CountW-1:0] n_eff;
  logic [CountW-1:0] loop_len;
  logic              looping;

  always_comb begin
    n_eff    = (32'(count_q) > 32'(MEMORY_DEPTH)) ? CountW'(MEMORY_DEPTH) : count_q;
    loop_len = finish_q - CountW'(begin_q);
    looping  = loop_en_q && (CountW'(begin_q) < finish_q) &&
               (CountW'(begin_q) < n_eff) && (finish_q <= n_eff);
  end

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // stage 0: clamp, split position, offset into the loop
  pipe_t            in_d;
  logic [PosW-1:0]  pos_c;

  always_comb begin
    pos_c       = position_i[PosW-1] ? '0 : position_i;
    in_d.rd     = func_i;
    in_d.widx   = write_index_i;
    in_d.wval   = write_value_i;
    in_d.frac   = pos_c[FW-1:0];
    in_d.ipart  = pos_c[PosW-1:FW];
    in_d.offs   = pos_c[PosW-1:FW] - IW'(begin_q);
    in_d.pin    = looping && (loop_len <= CountW'(1));
    in_d.wrap   = looping && (loop_len > CountW'(1)) &&
                  (pos_c[PosW-1:FW] >= IW'(finish_q));
  end

  // modulo pipeline: stage k brings in bit IW-1-k of the offset
  pipe_t         pipe_q [IW+1];
  logic          v_q    [IW+1];
  logic [RW-1:0] rem_q  [IW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= in_d;
    rem_q[0]  <= '0;
  end

  for (genvar k = 0; k < IW; k++) begin : g_mod
    logic [RW-1:0] sh_d;
    logic [RW-1:0] rem_d;

    always_comb begin
      sh_d  = {rem_q[k][RW-2:0], pipe_q[k].offs[IW-1-k]};
      rem_d = (sh_d >= RW'(loop_len)) ? sh_d - RW'(loop_len) : sh_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      pipe_q[k+1] <= pipe_q[k];
      rem_q[k+1]  <= rem_d;
    end
  end

  // address stage
  pipe_t          lst;
  logic [IW-1:0]  idx_c;
  logic [IW-1:0]  nxt_c;
  logic [IW-1:0]  i1_c;
  logic [FW-1:0]  fr_c;
  logic           zero_c;
  logic [AW-1:0]  a0_d, a1_d;

  assign lst = pipe_q[IW];

  always_comb begin
    if (lst.pin) begin
      idx_c = IW'(begin_q);
      fr_c  = '0;
    end else if (lst.wrap) begin
      idx_c = IW'(begin_q) + IW'(rem_q[IW]);
      fr_c  = lst.frac;
    end else begin
      idx_c = lst.ipart;
      fr_c  = lst.frac;
    end
    nxt_c = idx_c + IW'(1);
    if (looping) begin
      i1_c = (nxt_c >= IW'(finish_q)) ? IW'(begin_q) : nxt_c;
    end else begin
      i1_c = (nxt_c >= IW'(n_eff)) ? IW'(n_eff - CountW'(1)) : nxt_c;
    end
    zero_c = (n_eff == '0) || (idx_c >= IW'(n_eff)) || (i1_c >= IW'(n_eff));
    a0_d   = AW'(idx_c);
    a1_d   = AW'(i1_c);
    // single stored sample reads entry zero as is
    if (n_eff == CountW'(1)) begin
      zero_c = 1'b0;
      fr_c   = '0;
      a0_d   = '0;
      a1_d   = '0;
    end
  end

  logic               a_valid_q, a_rd_q, a_zero_q;
  logic [IndexW-1:0]  a_widx_q;
  logic [SampleW-1:0] a_wval_q;
  logic [AW-1:0]      a_i0_q, a_i1_q;
  logic [FW-1:0]      a_fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= v_q[IW];
    end
  end

  always_ff @(posedge clk_i) begin
    a_rd_q   <= lst.rd;
    a_zero_q <= zero_c;
    a_widx_q <= lst.widx;
    a_wval_q <= lst.wval;
    a_i0_q   <= a0_d;
    a_i1_q   <= a1_d;
    a_fr_q   <= fr_c;
  end

  // memory stage: writes land here so reads stay in order with them
  logic [SampleW-1:0] mem [MEMORY_DEPTH];
  logic               wr_ok;
  logic [SampleW-1:0] s0_q, s1_q;
  logic               m_valid_q, m_zero_q;
  logic [FW-1:0]      m_fr_q;

  assign wr_ok = a_valid_q && !a_rd_q && (32'(a_widx_q) < 32'(MEMORY_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[AW'(a_widx_q)] <= a_wval_q;
    end
    s0_q     <= mem[a_i0_q];
    s1_q     <= mem[a_i1_q];
    m_zero_q <= a_zero_q;
    m_fr_q   <= a_fr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= a_valid_q && a_rd_q;
    end
  end

  // product stage
  localparam int unsigned PW = SampleW + 1 + FW + 1;
  logic signed [SampleW:0]   diff_c;
  logic signed [PW-1:0]      prod_d;
  logic signed [PW-1:0]      prod_q;
  logic signed [SampleW-1:0] p_s0_q;
  logic                      p_valid_q, p_zero_q;

  always_comb begin
    diff_c = (SampleW+1)'($signed(s1_q)) - (SampleW+1)'($signed(s0_q));
    prod_d = PW'(diff_c) * PW'($signed({1'b0, m_fr_q}));
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    p_s0_q   <= $signed(s0_q);
    p_zero_q <= m_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= m_valid_q;
    end
  end

  // output stage, arithmetic shift drops the fraction toward minus infinity
  logic signed [PW-1:0]      q_c;
  logic signed [SampleW-1:0] out_d;
  logic signed [SampleW-1:0] out_q;
  logic                      out_valid_q;

  always_comb begin
    q_c   = prod_q >>> FW;
    out_d = p_zero_q ? '0 : SampleW'(PW'(p_s0_q) + q_c);
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= p_valid_q;
    end
  end

  assign sample_valid_o = out_valid_q;
  assign sample_out_o   = out_q;

endmodule

`default_nettype wire

// ===== sv/lsi_checker.sv =====
// ----------------------------------------------------------------------------
// lsi_checker
// Port level checks of the looped sample interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_checker #(
  parameter int unsigned Latency = 37
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic func_i,
  input wire logic sample_valid_o
);

  // every result strobe comes from a read transfer a fixed time back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(start_i && !busy_o && func_i, Latency))
    else $error("result without matching read");

  // a write transfer never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !func_i) |-> ##Latency !sample_valid_o)
    else $error("result from a write");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !sample_valid_o)
    else $error("result right after reset");

endmodule

bind looped_sample_interpolator lsi_checker #(.Latency(LATENCY)) u_lsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .func_i         (func_i),
  .sample_valid_o (sample_valid_o)
);

`default_nettype wire

// ===== dv/tb_looped_sample_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_looped_sample_interpolator
// Self-checking bench: loads the sample memory, sweeps loop and count settings,
// and checks each interpolated read against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_looped_sample_interpolator;
  import lsi_pkg::*;

  localparam int Depth    = DefaultDepth;
  localparam int FracBits = DefaultFracBits;
  localparam int Latency  = PosW - FracBits + 4;
  localparam int FillCnt  = 320;
  localparam int TopCnt   = 8;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic                      func_i = 1'b0;
  logic [IndexW-1:0]         write_index_i = '0;
  logic signed [SampleW-1:0] write_value_i = '0;
  logic signed [PosW-1:0]    position_i = '0;
  logic                      sample_valid_o;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      cfg_we_i = 1'b0;
  cfg_idx_e                  cfg_idx_i = CfgSampleCount;
  logic [CfgDataW-1:0]       cfg_data_i = '0;

  looped_sample_interpolator uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .write_index_i, .write_value_i,
    .position_i, .sample_valid_o, .sample_out_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // shadow state of the block
  logic [SampleW-1:0] shadow_mem [Depth];
  bit                 written [Depth];
  bit                 hit_unwritten = 1'b0;
  logic [CountW-1:0]  sh_count = '0;
  logic               sh_loop_en = 1'b0;
  logic [BeginW-1:0]  sh_begin = '0;
  logic [CountW-1:0]  sh_finish = '0;

  logic signed [SampleW-1:0] sample_q [$];
  int errors = 0;
  bit no_gaps = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL looped_sample_interpolator");
    $finish;
  end

  function automatic logic signed [SampleW-1:0] mem_val(longint idx);
    if (!written[idx]) hit_unwritten = 1'b1;
    return $signed(shadow_mem[idx]);
  endfunction

  function automatic logic signed [SampleW-1:0] interp_sample(logic signed [PosW-1:0] p);
    longint n, pos, a, b, len, i0, i1, frac, s0, s1, prod;
    bit looping;
    n = (sh_count > Depth) ? Depth : sh_count;
    if (n == 0) return '0;
    pos = (p < 0) ? 0 : longint'(p);
    looping = sh_loop_en && (sh_begin < sh_finish) && (sh_begin < n) && (sh_finish <= n);
    if (looping) begin
      a = longint'(sh_begin) << FracBits;
      b = longint'(sh_finish) << FracBits;
      len = longint'(sh_finish) - longint'(sh_begin);
      if (len <= 1) pos = a;
      else if (pos >= b) pos = a + (pos - a) % (len << FracBits);
    end
    if (n == 1) return mem_val(0);
    i0 = pos >> FracBits;
    frac = pos & ((longint'(1) << FracBits) - 1);
    if (i0 >= n) return '0;
    i1 = i0 + 1;
    if (!looping) begin
      if (i1 >= n) i1 = n - 1;
    end else begin
      if (i1 >= sh_finish) i1 = sh_begin;
      if (i1 >= n) return '0;
    end
    s0 = mem_val(i0);
    s1 = mem_val(i1);
    prod = (s1 - s0) * frac;
    // arithmetic shift floors toward minus infinity
    return SampleW'(s0 + (prod >>> FracBits));
  endfunction

  task automatic idle_gap();
    int g;
    if (no_gaps) return;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: g = 0;
      6, 7, 8: g = $urandom_range(1, 3);
      default: g = $urandom_range(5, 40);
    endcase
    if (g > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // one transfer of an input item
  task automatic send_item(logic fn, logic [IndexW-1:0] idx, logic [SampleW-1:0] val,
                           logic signed [PosW-1:0] pos);
    @(negedge clk_i);
    start_i = 1'b1;
    func_i = fn;
    write_index_i = idx;
    write_value_i = val;
    position_i = pos;
    do @(posedge clk_i); while (busy_o);
    if (fn) sample_q.push_back(interp_sample(pos));
    else begin
      shadow_mem[idx] = val;
      written[idx] = 1'b1;
    end
    idle_gap();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      CfgSampleCount: sh_count = data[CountW-1:0];
      CfgLoopEnable:  sh_loop_en = data[0];
      CfgLoopBegin:   sh_begin = data[BeginW-1:0];
      CfgLoopFinish:  sh_finish = data[CountW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_playback(int cnt, bit en, int lb, int lf);
    wait_drained();
    cfg_write(CfgSampleCount, CfgDataW'(cnt));
    cfg_write(CfgLoopEnable, CfgDataW'(en));
    cfg_write(CfgLoopBegin, CfgDataW'(lb));
    cfg_write(CfgLoopFinish, CfgDataW'(lf));
  endtask

  function automatic logic signed [PosW-1:0] at_index(longint ip, longint frac);
    return PosW'((ip << FracBits) | frac);
  endfunction

  function automatic logic signed [PosW-1:0] pick_position();
    longint lim, frac;
    lim = (sh_count > sh_finish) ? sh_count : sh_finish;
    lim = (lim > Depth) ? Depth : lim;
    frac = $urandom_range(0, (1 << FracBits) - 1);
    case ($urandom_range(0, 9))
      0: return PosW'({$urandom, $urandom});
      1: return -$signed(PosW'($urandom_range(1, 1 << 20)));
      2, 3: return at_index($urandom_range(0, 32'(4 * lim + 8)), frac);
      default: return at_index($urandom_range(0, 32'(lim + 2)), frac);
    endcase
  endfunction

  // a read position whose entries have all been loaded
  function automatic logic signed [PosW-1:0] safe_position();
    logic signed [PosW-1:0] p;
    for (int t = 0; t < 8; t++) begin
      p = pick_position();
      hit_unwritten = 1'b0;
      void'(interp_sample(p));
      if (!hit_unwritten) return p;
    end
    return at_index($urandom_range(0, FillCnt - 2), $urandom_range(0, (1 << FracBits) - 1));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && sample_valid_o) begin
      if (sample_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample %0d", sample_out_o);
      end else begin
        if (sample_out_o !== sample_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("sample mismatch: expected %0d actual %0d", sample_q[0], sample_out_o);
        end
        void'(sample_q.pop_front());
      end
    end
  end

  task automatic test_fill();
    no_gaps = 1'b1;
    for (int i = 0; i < FillCnt; i++) send_item(1'b0, IndexW'(i), SampleW'($urandom), '0);
    for (int i = Depth - TopCnt; i < Depth; i++)
      send_item(1'b0, IndexW'(i), SampleW'($urandom), '0);
    no_gaps = 1'b0;
  endtask

  task automatic test_directed();
    send_item(1'b0, 16'd0, 16'h8000, '0);
    send_item(1'b0, 16'd1, 16'h7fff, '0);
    send_item(1'b0, 16'hffff, 16'h7fff, '0);
    send_item(1'b0, 16'hfffe, 16'h8000, '0);
    // empty memory
    send_item(1'b1, '0, '0, at_index(0, 16'h8000));
    // single sample
    set_playback(1, 1'b0, 0, 0);
    send_item(1'b1, '0, '0, at_index(5, 16'h1234));
    // full range without loop, extremes and negative positions
    set_playback(Depth, 1'b0, 0, 0);
    send_item(1'b1, '0, '0, at_index(0, 16'hffff));
    send_item(1'b1, '0, '0, at_index(0, 16'h0001));
    send_item(1'b1, '0, '0, {1'b1, 47'd0});
    send_item(1'b1, '0, '0, {1'b0, {47{1'b1}}});
    send_item(1'b1, '0, '0, at_index(Depth - 1, 16'hffff));
    send_item(1'b1, '0, '0, at_index(Depth, 16'h0));
    // count beyond memory, loop of length one at the top entry
    set_playback(131071, 1'b1, 65535, 65536);
    send_item(1'b1, '0, '0, at_index(3, 16'h4000));
    send_item(1'b1, '0, '0, {1'b0, {47{1'b1}}});
    // full loop, wrap at the end
    set_playback(Depth, 1'b1, 0, Depth);
    send_item(1'b1, '0, '0, at_index(Depth - 1, 16'h8000));
    send_item(1'b1, '0, '0, at_index(Depth, 16'h0001));
    send_item(1'b1, '0, '0, {1'b0, {47{1'b1}}});
    // loop invalid: finish past count
    set_playback(10, 1'b1, 2, 11);
    send_item(1'b1, '0, '0, at_index(9, 16'h8000));
    send_item(1'b1, '0, '0, at_index(10, 16'h0));
  endtask

  task automatic test_random();
    int lb, lf, cnt;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_playback(16, 1'b1, 3, 11);
        1: set_playback(16, 1'b0, 3, 11);
        2: set_playback(2, 1'b1, 0, 2);
        3: set_playback(Depth, 1'b1, 0, Depth);
        4: set_playback(0, 1'b1, 0, 0);
        default: begin
          cnt = $urandom_range(1, 300);
          lb = $urandom_range(0, cnt);
          lf = $urandom_range(0, cnt + 1);
          set_playback(cnt, $urandom_range(0, 3) != 0, lb, lf);
        end
      endcase
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 7) == 0) send_item(1'b0, IndexW'($urandom), SampleW'($urandom), '0);
        else send_item(1'b1, IndexW'($urandom), SampleW'($urandom), safe_position());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill();
    test_directed();
    test_random();
    wait_drained();
    if (errors == 0) $display("PASS looped_sample_interpolator");
    else $display("FAIL looped_sample_interpolator");
    $finish;
  end
endmodule

// ===== looped_sample_interpolator.f =====
sv/lsi_pkg.sv
sv/looped_sample_interpolator.sv
sv/lsi_checker.sv
dv/tb_looped_sample_interpolator.sv
